// ===== hw/rtl/tmh_pkg.sv =====
// Package for the timer min-heap scheduler: request and result types,
// command codes, sequencer states and the saturating deadline add.
// No dependencies.
package tmh_pkg;

  localparam int TIMER_COUNT_DEF = 64;
  localparam logic [47:0] T48_MAX = 48'hFFFF_FFFF_FFFF;

  typedef enum logic [1:0] {
    CMD_START = 2'd0,
    CMD_STOP  = 2'd1,
    CMD_POLL  = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_e;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [5:0]  timer_id;
    logic [47:0] now_time;
    logic [39:0] duration;
    logic        repeat_req;
  } in_t;

  typedef struct packed {
    logic [5:0]  expired_id;
    logic        expired_valid;
    logic        last;
    logic        status;
    logic        heap_empty;
    logic [47:0] next_wait;
  } out_t;

  // Classified request handed from front to back.
  typedef struct packed {
    in_t  item;
    cmd_e cmd;
    logic id_ok;
  } job_t;

  // One heap slot: timer id plus its deadline.
  typedef struct packed {
    logic [5:0]  id;
    logic [47:0] key;
  } heap_ent_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_POS_RD,
    ST_ARM,
    ST_INS,
    ST_RM_START,
    ST_RM_LD,
    ST_DN_CHK,
    ST_DN_CMP,
    ST_UP_CHK,
    ST_UP_CMP,
    ST_PLACE,
    ST_PL_CHK,
    ST_PL_CMP,
    ST_RA_CHK,
    ST_RA_ID,
    ST_RA_CALC,
    ST_FIN_RD,
    ST_FIN,
    ST_ONE_OUT,
    ST_ES_CHK,
    ST_ES_OUT
  } state_e;

  function automatic logic [47:0] sat_add(logic [47:0] a, logic [47:0] b);
    logic [48:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[48] ? T48_MAX : s[47:0];
  endfunction

endpackage

// ===== hw/rtl/tmh_front.sv =====
// Front end: accepts requests, classifies command and id range,
// and queues them (two entries) for the back end. Uses tmh_pkg.
module tmh_front import tmh_pkg::*; #(
  parameter int TIMER_COUNT = TIMER_COUNT_DEF
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  input  in_t  in_data_i,
  output logic in_stall_o,
  output logic job_valid_o,
  output job_t job_o,
  input  logic job_pop_i
);

  job_t       q_mem [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] fill_q, fill_d;
  logic       push, pop;
  job_t       job_in;

  always_comb begin
    job_in.item  = in_data_i;
    job_in.cmd   = cmd_e'(in_data_i.cmd);
    job_in.id_ok = {1'b0, in_data_i.timer_id} < 7'(TIMER_COUNT);
  end

  assign in_stall_o  = (fill_q == 2'd2);
  assign job_valid_o = (fill_q != 2'd0);
  assign job_o       = q_mem[rd_ptr_q];
  assign push        = in_valid_i && !in_stall_o;
  assign pop         = job_pop_i && job_valid_o;

  always_comb begin
    wr_ptr_d = push ? !wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop ? !rd_ptr_q : rd_ptr_q;
    fill_d   = fill_q + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      fill_q   <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      fill_q   <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      q_mem[wr_ptr_q] <= job_in;
    end
  end

endmodule

// ===== hw/rtl/tmh_back.sv =====
// Back end: heap sequencer with slot, position, timer and pop-list
// memories, plus the result register. Uses tmh_pkg.
module tmh_back import tmh_pkg::*; #(
  parameter int TIMER_COUNT = TIMER_COUNT_DEF
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic job_valid_i,
  input  job_t job_i,
  output logic job_pop_o,
  output logic out_valid_o,
  output out_t out_data_o,
  input  logic out_stall_i
);

  localparam int IW = (TIMER_COUNT > 1) ? $clog2(TIMER_COUNT) : 1;

  // memories
  heap_ent_t   heap_mem [TIMER_COUNT];
  logic [5:0]  pos_mem  [TIMER_COUNT];
  logic [5:0]  pop_mem  [TIMER_COUNT];
  logic [47:0] dl_mem   [TIMER_COUNT];
  logic [39:0] per_mem  [TIMER_COUNT];
  logic        rep_mem  [TIMER_COUNT];
  logic [TIMER_COUNT-1:0] pv_q;

  heap_ent_t   ha_rd_q, hb_rd_q;
  logic [5:0]  pos_rd_q, pop_rd_q;
  logic [47:0] dl_rd_q;
  logic [39:0] per_rd_q;
  logic        rep_rd_q;

  // control and datapath registers
  state_e      state_q, state_d, ret_q, ret_d;
  in_t         cmd_q, cmd_d;
  cmd_e        op_q, op_d;
  logic [5:0]  hole_q, hole_d, rm_id_q, rm_id_d;
  heap_ent_t   mover_q, mover_d;
  logic [6:0]  cnt_q, cnt_d, n_q, n_d, k_q, k_d;
  logic        status_q, status_d, empty_q, empty_d;
  logic [47:0] wait_q, wait_d;
  logic        out_valid_q, out_valid_d;
  out_t        out_q, out_d;

  // memory controls
  logic [IW-1:0] ha_addr, hb_addr, pos_raddr, pop_raddr, tm_raddr;
  logic          heap_we, pos_we, pop_we, tm_we, dl_we, pv_clr;
  logic [IW-1:0] heap_waddr, pos_waddr, pop_waddr, tm_waddr, pv_clr_addr;
  heap_ent_t     heap_wdata;
  logic [5:0]    pos_wdata, pop_wdata;
  logic [47:0]   dl_wdata;

  // shared conditions
  logic [6:0]  child7, child_r7, csl7, cnt_m1;
  logic [5:0]  par6;
  logic        right_ok, take_r, dn_end, dn_stop, up_move, rm_last;
  logic        ins_full, pop_due, es_last, out_free, job_armed;
  heap_ent_t   csel;
  logic [47:0] arm_dl, rearm_dl;

  assign child7    = {hole_q, 1'b1};
  assign child_r7  = child7 + 7'd1;
  assign dn_end    = child7 >= cnt_q;
  assign right_ok  = child_r7 < cnt_q;
  assign take_r    = right_ok && (ha_rd_q.key > hb_rd_q.key);
  assign csel      = take_r ? hb_rd_q : ha_rd_q;
  assign csl7      = take_r ? child_r7 : child7;
  assign dn_stop   = mover_q.key < csel.key;
  assign par6      = (hole_q - 6'd1) >> 1;
  assign up_move   = ha_rd_q.key > mover_q.key;
  assign cnt_m1    = cnt_q - 7'd1;
  assign rm_last   = {1'b0, hole_q} == cnt_m1;
  assign ins_full  = cnt_q >= 7'(TIMER_COUNT);
  assign pop_due   = ha_rd_q.key <= cmd_q.now_time;
  assign es_last   = (k_q + 7'd1) == n_q;
  assign out_free  = !out_valid_q || !out_stall_i;
  assign job_armed = job_i.id_ok && pv_q[job_i.item.timer_id[IW-1:0]];
  assign arm_dl    = sat_add(cmd_q.now_time, {8'd0, cmd_q.duration});
  assign rearm_dl  = sat_add(dl_rd_q, {8'd0, per_rd_q});

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (job_valid_i) begin
          unique case (job_i.cmd)
            CMD_START: state_d = !job_i.id_ok ? ST_FIN_RD :
                                 (job_armed ? ST_POS_RD : ST_ARM);
            CMD_STOP:  state_d = job_armed ? ST_POS_RD : ST_FIN_RD;
            CMD_POLL:  state_d = ST_PL_CHK;
            default:   state_d = ST_FIN_RD;
          endcase
        end
      end
      ST_POS_RD:   state_d = ST_RM_START;
      ST_ARM:      state_d = ST_INS;
      ST_INS:      state_d = ins_full ? ret_q : ST_UP_CHK;
      ST_RM_START: state_d = rm_last ? ret_q : ST_RM_LD;
      ST_RM_LD:    state_d = ST_DN_CHK;
      ST_DN_CHK:   state_d = dn_end ? ST_UP_CHK : ST_DN_CMP;
      ST_DN_CMP:   state_d = dn_stop ? ST_UP_CHK : ST_DN_CHK;
      ST_UP_CHK:   state_d = (hole_q == 6'd0) ? ST_PLACE : ST_UP_CMP;
      ST_UP_CMP:   state_d = up_move ? ST_UP_CHK : ST_PLACE;
      ST_PLACE:    state_d = ret_q;
      ST_PL_CHK:   state_d = (cnt_q == 7'd0) ? ST_RA_CHK : ST_PL_CMP;
      ST_PL_CMP:   state_d = pop_due ? ST_RM_START : ST_RA_CHK;
      ST_RA_CHK:   state_d = (k_q == n_q) ? ST_FIN_RD : ST_RA_ID;
      ST_RA_ID:    state_d = ST_RA_CALC;
      ST_RA_CALC:  state_d = rep_rd_q ? ST_INS : ST_RA_CHK;
      ST_FIN_RD:   state_d = ST_FIN;
      ST_FIN:      state_d = (op_q == CMD_POLL && n_q != 7'd0) ? ST_ES_CHK : ST_ONE_OUT;
      ST_ONE_OUT:  state_d = out_free ? ST_IDLE : ST_ONE_OUT;
      ST_ES_CHK:   state_d = ST_ES_OUT;
      ST_ES_OUT:   state_d = !out_free ? ST_ES_OUT : (es_last ? ST_IDLE : ST_ES_CHK);
      default:     state_d = ST_IDLE;
    endcase
  end

  // datapath and memory controls
  always_comb begin
    ret_d = ret_q; cmd_d = cmd_q; op_d = op_q; hole_d = hole_q; rm_id_d = rm_id_q;
    mover_d = mover_q; cnt_d = cnt_q; n_d = n_q; k_d = k_q;
    status_d = status_q; empty_d = empty_q; wait_d = wait_q;
    out_d = out_q;
    out_valid_d = out_valid_q && out_stall_i;
    job_pop_o = 1'b0;
    ha_addr = '0; hb_addr = '0;
    pos_raddr = job_i.item.timer_id[IW-1:0];
    pop_raddr = k_q[IW-1:0];
    tm_raddr  = pop_rd_q[IW-1:0];
    heap_we = 1'b0; heap_waddr = hole_q[IW-1:0]; heap_wdata = mover_q;
    pos_we = 1'b0; pos_waddr = mover_q.id[IW-1:0]; pos_wdata = hole_q;
    pop_we = 1'b0; pop_waddr = n_q[IW-1:0]; pop_wdata = ha_rd_q.id;
    tm_we = 1'b0; tm_waddr = cmd_q.timer_id[IW-1:0];
    dl_we = 1'b0; dl_wdata = arm_dl;
    pv_clr = 1'b0; pv_clr_addr = rm_id_q[IW-1:0];
    unique case (state_q)
      ST_IDLE: begin
        job_pop_o = job_valid_i;
        if (job_valid_i) begin
          cmd_d = job_i.item;
          op_d = job_i.cmd;
          n_d = 7'd0;
          k_d = 7'd0;
          status_d = (job_i.cmd == CMD_STOP) && !job_armed;
        end
      end
      ST_POS_RD: begin
        hole_d = pos_rd_q;
        rm_id_d = cmd_q.timer_id;
        ret_d = (op_q == CMD_START) ? ST_ARM : ST_FIN_RD;
      end
      ST_ARM: begin
        tm_we = 1'b1;
        dl_we = 1'b1;
        mover_d = '{id: cmd_q.timer_id, key: arm_dl};
        ret_d = ST_FIN_RD;
      end
      ST_INS: begin
        if (!ins_full) begin
          hole_d = cnt_q[5:0];
          cnt_d = cnt_q + 7'd1;
        end
      end
      ST_RM_START: begin
        pv_clr = 1'b1;
        cnt_d = cnt_m1;
        ha_addr = cnt_m1[IW-1:0];
      end
      ST_RM_LD: mover_d = ha_rd_q;
      ST_DN_CHK: begin
        ha_addr = child7[IW-1:0];
        hb_addr = child_r7[IW-1:0];
      end
      ST_DN_CMP: begin
        if (!dn_stop) begin
          heap_we = 1'b1; heap_wdata = csel;
          pos_we = 1'b1; pos_waddr = csel.id[IW-1:0];
          hole_d = csl7[5:0];
        end
      end
      ST_UP_CHK: ha_addr = par6[IW-1:0];
      ST_UP_CMP: begin
        if (up_move) begin
          heap_we = 1'b1; heap_wdata = ha_rd_q;
          pos_we = 1'b1; pos_waddr = ha_rd_q.id[IW-1:0];
          hole_d = par6;
        end
      end
      ST_PLACE: begin
        heap_we = 1'b1;
        pos_we = 1'b1;
      end
      ST_PL_CHK: ha_addr = '0;
      ST_PL_CMP: begin
        if (pop_due) begin
          pop_we = 1'b1;
          n_d = n_q + 7'd1;
          hole_d = 6'd0;
          rm_id_d = ha_rd_q.id;
          ret_d = ST_PL_CHK;
        end
      end
      ST_RA_CHK: ;
      ST_RA_ID: ;
      ST_RA_CALC: begin
        k_d = k_q + 7'd1;
        if (rep_rd_q) begin
          dl_we = 1'b1;
          tm_waddr = pop_rd_q[IW-1:0];
          dl_wdata = rearm_dl;
          mover_d = '{id: pop_rd_q, key: rearm_dl};
          ret_d = ST_RA_CHK;
        end
      end
      ST_FIN_RD: ha_addr = '0;
      ST_FIN: begin
        empty_d = (cnt_q == 7'd0);
        wait_d = (cnt_q != 7'd0 && ha_rd_q.key > cmd_q.now_time) ?
                 ha_rd_q.key - cmd_q.now_time : 48'd0;
        k_d = 7'd0;
      end
      ST_ONE_OUT: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_d = '{expired_id: 6'd0, expired_valid: 1'b0, last: 1'b1,
                    status: status_q, heap_empty: empty_q, next_wait: wait_q};
        end
      end
      ST_ES_CHK: ;
      ST_ES_OUT: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_d = '{expired_id: pop_rd_q, expired_valid: 1'b1, last: es_last,
                    status: 1'b0, heap_empty: es_last && empty_q,
                    next_wait: es_last ? wait_q : 48'd0};
          k_d = k_q + 7'd1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      ret_q       <= ST_IDLE;
      cnt_q       <= 7'd0;
      n_q         <= 7'd0;
      k_q         <= 7'd0;
      out_valid_q <= 1'b0;
      pv_q        <= '0;
    end else begin
      state_q     <= state_d;
      ret_q       <= ret_d;
      cnt_q       <= cnt_d;
      n_q         <= n_d;
      k_q         <= k_d;
      out_valid_q <= out_valid_d;
      if (pos_we) pv_q[pos_waddr] <= 1'b1;
      if (pv_clr) pv_q[pv_clr_addr] <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q    <= cmd_d;
    op_q     <= op_d;
    hole_q   <= hole_d;
    rm_id_q  <= rm_id_d;
    mover_q  <= mover_d;
    status_q <= status_d;
    empty_q  <= empty_d;
    wait_q   <= wait_d;
    out_q    <= out_d;
  end

  // memories, registered reads
  always_ff @(posedge clk_i) begin
    if (heap_we) heap_mem[heap_waddr] <= heap_wdata;
    ha_rd_q <= heap_mem[ha_addr];
    hb_rd_q <= heap_mem[hb_addr];
  end

  always_ff @(posedge clk_i) begin
    if (pos_we) pos_mem[pos_waddr] <= pos_wdata;
    pos_rd_q <= pos_mem[pos_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (pop_we) pop_mem[pop_waddr] <= pop_wdata;
    pop_rd_q <= pop_mem[pop_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (tm_we) begin
      per_mem[tm_waddr] <= cmd_q.duration;
      rep_mem[tm_waddr] <= cmd_q.repeat_req;
    end
    if (dl_we) dl_mem[tm_waddr] <= dl_wdata;
    dl_rd_q  <= dl_mem[tm_raddr];
    per_rd_q <= per_mem[tm_raddr];
    rep_rd_q <= rep_mem[tm_raddr];
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// ===== hw/rtl/timer_min_heap_scheduler.sv =====
// Timer min-heap scheduler: start/stop/poll requests on a 64-deep binary heap.
// A start first removes the timer if it is armed, then inserts it and sifts it up;
// a stop removes an armed timer. A poll pops every due timer, re-arms the
// repeating ones afterwards, then gives one result per popped timer.
// Throughput: one request in the back end at a time; two more queue in front.
// Reset: async, clears count, valid bits and handshakes; memories are not reset, and unwritten entries are never used.
module timer_min_heap_scheduler import tmh_pkg::*; #(
  parameter int TIMER_COUNT = TIMER_COUNT_DEF
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  input  in_t  in_data_i,
  output logic in_stall_o,
  output logic out_valid_o,
  output out_t out_data_o,
  input  logic out_stall_i
);

  // front -> back request queue
  job_t job;
  logic job_valid;
  logic job_pop;

  // Front classifies each request and buffers it, so new requests are
  // taken while the back end sifts the heap.
  tmh_front #(.TIMER_COUNT(TIMER_COUNT)) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_data_i   (in_data_i),
    .in_stall_o  (in_stall_o),
    .job_valid_o (job_valid),
    .job_o       (job),
    .job_pop_i   (job_pop)
  );

  // Back runs the heap sequencer; results leave through its output
  // register, which the consumer may stall independently.
  tmh_back #(.TIMER_COUNT(TIMER_COUNT)) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_valid_i (job_valid),
    .job_i       (job),
    .job_pop_o   (job_pop),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o),
    .out_stall_i (out_stall_i)
  );

endmodule

// ===== hw/rtl/tmh_checker.sv =====
// Port-level checker for the timer min-heap scheduler and its bind.
// Uses tmh_pkg.
module tmh_checker import tmh_pkg::*; (
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid_i,
  input in_t  in_data_i,
  input logic in_stall_o,
  input logic out_valid_o,
  input out_t out_data_o,
  input logic out_stall_i
);

  // stalled request stays offered and unchanged
  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_stall_o |=> in_valid_i && $stable(in_data_i))
    else $error("request changed while stalled");

  // stalled result stays offered
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped while stalled");

  // only expired-timer results can be non-final
  a_nonlast_expired: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.last |-> out_data_o.expired_valid)
    else $error("non-final result without expired timer");

  // heap summary only on final result
  a_nonlast_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.last |->
      !out_data_o.heap_empty && out_data_o.next_wait == 48'd0)
    else $error("summary on non-final result");

  // empty heap has no wait
  a_empty_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.heap_empty |-> out_data_o.next_wait == 48'd0)
    else $error("wait reported on empty heap");

endmodule

bind timer_min_heap_scheduler tmh_checker u_tmh_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_data_i   (in_data_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_data_o  (out_data_o),
  .out_stall_i (out_stall_i)
);

// ===== dv/tb_timer_min_heap_scheduler.sv =====
`timescale 1ns / 1ps
// Testbench for timer_min_heap_scheduler: random and directed start, stop and
// poll requests, with results checked against an in-bench heap predictor.
// Depends on tmh_pkg and the scheduler RTL.

// Scoreboard: keeps its own heap of timers and a queue of expected results.
class timer_heap_scoreboard;
  tmh_pkg::out_t result_q[$];
  logic [5:0]  order[64];
  logic [6:0]  count;
  logic [6:0]  pos[64];
  logic [47:0] deadline[64];
  logic [39:0] period[64];
  logic        repeats[64];
  int          n_err;
  int          n_checked;

  function new();
    count = 0;
    n_err = 0;
    n_checked = 0;
    for (int i = 0; i < 64; i++) begin
      pos[i] = 7'd127;
      order[i] = '0;
    end
  endfunction

  function logic [47:0] key_of(int slot);
    return deadline[order[slot]];
  endfunction

  function void put(int slot, logic [5:0] id);
    order[slot] = id;
    pos[id] = 7'(slot);
  endfunction

  function logic [47:0] add_sat(logic [47:0] a, logic [47:0] b);
    logic [48:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[48] ? 48'hFFFF_FFFF_FFFF : s[47:0];
  endfunction

  function void insert(logic [5:0] id);
    int hole;
    logic [47:0] k;
    k = deadline[id];
    if (count >= 64) return;
    hole = count;
    count++;
    while (hole > 0 && key_of((hole - 1) / 2) > k) begin
      put(hole, order[(hole - 1) / 2]);
      hole = (hole - 1) / 2;
    end
    put(hole, id);
  endfunction

  function void remove(int slot);
    int hole, child;
    logic [5:0] mover;
    logic [47:0] k;
    if (slot >= count) return;
    pos[order[slot]] = 7'd127;
    count--;
    if (slot == count) return;
    mover = order[count];
    k = deadline[mover];
    hole = slot;
    forever begin
      child = 2 * hole + 1;
      if (child >= count) break;
      if (child + 1 < count && key_of(child) > key_of(child + 1)) child++;
      if (k < key_of(child)) break;
      put(hole, order[child]);
      hole = child;
    end
    while (hole > 0 && key_of((hole - 1) / 2) > k) begin
      put(hole, order[(hole - 1) / 2]);
      hole = (hole - 1) / 2;
    end
    put(hole, mover);
  endfunction

  function void push_result(logic [5:0] id, logic vld, logic lst, logic st,
                            logic [47:0] now);
    tmh_pkg::out_t r;
    r = '0;
    r.expired_id = id;
    r.expired_valid = vld;
    r.last = lst;
    r.status = st;
    if (lst) begin
      r.heap_empty = (count == 0);
      if (count != 0 && key_of(0) > now) r.next_wait = key_of(0) - now;
    end
    result_q.push_back(r);
  endfunction

  // Note an accepted request: update the heap and queue its results.
  function void note_request(tmh_pkg::in_t req);
    logic [5:0] popped[$];
    logic armed;
    armed = pos[req.timer_id] != 7'd127;
    case (tmh_pkg::cmd_e'(req.cmd))
      tmh_pkg::CMD_START: begin
        if (armed) remove(pos[req.timer_id]);
        period[req.timer_id] = req.duration;
        repeats[req.timer_id] = req.repeat_req;
        deadline[req.timer_id] = add_sat(req.now_time, {8'd0, req.duration});
        insert(req.timer_id);
        push_result('0, 1'b0, 1'b1, 1'b0, req.now_time);
      end
      tmh_pkg::CMD_STOP: begin
        if (armed) remove(pos[req.timer_id]);
        push_result('0, 1'b0, 1'b1, !armed, req.now_time);
      end
      tmh_pkg::CMD_POLL: begin
        while (count > 0 && key_of(0) <= req.now_time) begin
          popped.push_back(order[0]);
          remove(0);
        end
        // repeating timers go back in only after every pop
        foreach (popped[k]) if (repeats[popped[k]]) begin
          deadline[popped[k]] = add_sat(deadline[popped[k]], {8'd0, period[popped[k]]});
          insert(popped[k]);
        end
        if (popped.size() == 0) push_result('0, 1'b0, 1'b1, 1'b0, req.now_time);
        foreach (popped[k])
          push_result(popped[k], 1'b1, k == popped.size() - 1, 1'b0, req.now_time);
      end
      default: push_result('0, 1'b0, 1'b1, 1'b0, req.now_time);
    endcase
  endfunction

  function void check_result(tmh_pkg::out_t got);
    tmh_pkg::out_t exp_r;
    if (result_q.size() == 0) begin
      $error("result with none expected: %p", got);
      n_err++;
      return;
    end
    exp_r = result_q.pop_front();
    n_checked++;
    if (got.expired_id !== exp_r.expired_id) begin
      $error("expired_id exp %0d got %0d", exp_r.expired_id, got.expired_id); n_err++;
    end
    if (got.expired_valid !== exp_r.expired_valid) begin
      $error("expired_valid exp %0d got %0d", exp_r.expired_valid, got.expired_valid);
      n_err++;
    end
    if (got.last !== exp_r.last) begin
      $error("last exp %0d got %0d", exp_r.last, got.last); n_err++;
    end
    if (got.status !== exp_r.status) begin
      $error("status exp %0d got %0d", exp_r.status, got.status); n_err++;
    end
    if (got.heap_empty !== exp_r.heap_empty) begin
      $error("heap_empty exp %0d got %0d", exp_r.heap_empty, got.heap_empty); n_err++;
    end
    if (got.next_wait !== exp_r.next_wait) begin
      $error("next_wait exp %0h got %0h", exp_r.next_wait, got.next_wait); n_err++;
    end
  endfunction
endclass

module tb_timer_min_heap_scheduler;
  import tmh_pkg::*;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int LONG_HOLD = 400;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  in_t  in_data_i = '0;
  logic in_stall_o;
  logic out_valid_o;
  out_t out_data_o;
  logic out_stall_i = 1'b0;

  timer_heap_scoreboard sb;

  // idle rates in percent, changed per phase
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  bit hold_recv = 1'b0;
  bit stim_done = 1'b0;
  int idle_cycles = 0;
  int n_sent = 0;
  int n_polls_fired = 0;
  logic [47:0] sim_now = 48'd1000;

  always #10 clk_i = ~clk_i;

  timer_min_heap_scheduler DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_data_i  (in_data_i),
    .in_stall_o (in_stall_o),
    .out_valid_o(out_valid_o),
    .out_data_o (out_data_o),
    .out_stall_i(out_stall_i)
  );

  // Result side: check on accept, then pick next cycle's stall.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      sb.check_result(out_data_o);
      if (out_data_o.expired_valid) n_polls_fired++;
    end
    if (hold_recv) out_stall_i <= 1'b1;
    else out_stall_i <= ($urandom_range(99) < recv_stall_pct);
  end

  // Watchdog: cycles with nothing accepted on either side.
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no progress, %0d results outstanding", sb.result_q.size());
      $display("FAILED: results differ");
      $finish;
    end
  end

  // Offer one request, with random idle cycles first; returns at the accepting
  // edge with valid still high, so a following request can go back to back.
  task automatic send_request(in_t req);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i <= req;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    sb.note_request(req);
    n_sent++;
  endtask

  function automatic in_t make_req(cmd_e c, logic [5:0] id, logic [47:0] now,
                                   logic [39:0] dur, logic rep);
    in_t r;
    r.cmd = c;
    r.timer_id = id;
    r.now_time = now;
    r.duration = dur;
    r.repeat_req = rep;
    return r;
  endfunction

  // Random request: mostly short durations near the running clock so polls pop.
  function automatic in_t rand_req();
    int sel;
    logic [39:0] dur;
    sel = $urandom_range(99);
    sim_now = sim_now + 48'($urandom_range(40));
    if ($urandom_range(19) == 0) dur = 40'({$urandom, $urandom});
    else dur = 40'($urandom_range(120));
    if (sel < 50)
      return make_req(CMD_START, 6'($urandom_range(63)), sim_now, dur,
                      1'($urandom_range(1)));
    if (sel < 65)
      return make_req(CMD_STOP, 6'($urandom_range(63)), sim_now, dur,
                      1'($urandom_range(1)));
    if (sel < 97)
      return make_req(CMD_POLL, 6'($urandom_range(63)), sim_now, dur,
                      1'($urandom_range(1)));
    // noise: unused code or fully random fields
    return make_req(cmd_e'(2'($urandom_range(3))), 6'($urandom),
                    48'({$urandom, $urandom}), 40'({$urandom, $urandom}),
                    1'($urandom_range(1)));
  endfunction

  // Stop offering and wait until every expected result has come.
  task automatic drain();
    in_valid_i <= 1'b0;
    while (sb.result_q.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
  endtask

  initial begin
    sb = new();
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: empty poll, unarmed stop, restart, saturation, equal deadlines,
    // zero-period repeat, unused code, field extremes.
    send_request(make_req(CMD_POLL, 6'd0, 48'd0, 40'd0, 1'b0));
    send_request(make_req(CMD_STOP, 6'd63, 48'd5, 40'd0, 1'b0));
    send_request(make_req(CMD_START, 6'd63, 48'hFFFF_FFFF_FFF0, 40'hFF_FFFF_FFFF, 1'b1));
    send_request(make_req(CMD_START, 6'd1, 48'd100, 40'd50, 1'b0));
    send_request(make_req(CMD_START, 6'd1, 48'd100, 40'd20, 1'b1));
    send_request(make_req(CMD_START, 6'd2, 48'd100, 40'd20, 1'b0));
    send_request(make_req(CMD_START, 6'd3, 48'd100, 40'd20, 1'b1));
    send_request(make_req(CMD_START, 6'd4, 48'd110, 40'd0, 1'b1));
    send_request(make_req(CMD_START, 6'd0, 48'd90, 40'd30, 1'b0));
    send_request(make_req(CMD_STOP, 6'd2, 48'd111, 40'd0, 1'b0));
    send_request(make_req(CMD_POLL, 6'd0, 48'd120, 40'd0, 1'b0));
    send_request(make_req(CMD_POLL, 6'd0, 48'd121, 40'd0, 1'b0));
    send_request(make_req(CMD_NONE, 6'd63, 48'hFFFF_FFFF_FFFF, 40'hFF_FFFF_FFFF, 1'b1));
    send_request(make_req(CMD_POLL, 6'd0, 48'hFFFF_FFFF_FFFF, 40'd0, 1'b0));
    send_request(make_req(CMD_POLL, 6'd0, 48'hFFFF_FFFF_FFFF, 40'd0, 1'b0));
    for (int i = 0; i < 64; i++) send_request(make_req(CMD_STOP, 6'(i), 48'd0, 40'd0, 1'b0));
    drain();

    // Full heap then one big poll: 64 results from one request.
    for (int i = 0; i < 64; i++)
      send_request(make_req(CMD_START, 6'(i), 48'd200, 40'($urandom_range(10)), 1'b0));
    send_request(make_req(CMD_POLL, 6'd0, 48'd300, 40'd0, 1'b0));

    // Receiver holds off while the sender keeps offering requests.
    fork
      begin
        hold_recv = 1'b1;
        repeat (LONG_HOLD) @(posedge clk_i);
        hold_recv = 1'b0;
      end
      for (int i = 0; i < 12; i++) send_request(rand_req());
    join
    drain();

    // Random phases with differing idle patterns.
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 87; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 87; end
        default: begin send_idle_pct = 18; recv_stall_pct = 18; end
      endcase
      for (int i = 0; i < 31; i++) send_request(rand_req());
      drain();
    end

    stim_done = 1'b1;
    $display("covered %0d requests, %0d results checked, %0d timer expirations",
             n_sent, sb.n_checked, n_polls_fired);
    if (sb.n_err == 0 && sb.result_q.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end
endmodule
